[rtl/stepper_stroke_pulse_generator_top_assert.svh]
// assertion macros for the stepper stroke pulse generator
// included by the rtl files that carry concurrent assertions; no other dependencies
`ifndef STEPPER_STROKE_PULSE_GENERATOR_TOP_ASSERT_SVH
`define STEPPER_STROKE_PULSE_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SSPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SSPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSPG_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SSPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/sspg_pkg.sv]
// shared types and constants of the stepper stroke pulse generator
// no dependencies; imported by every module of the block
package sspg_pkg;

   localparam int TIME_BITS     = 26;
   localparam int DUR_BITS      = 16;
   localparam int CMD_BITS      = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int PCT_BITS      = 7;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [CMD_BITS-1:0] CMD_TICK      = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_START_FWD = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_START_BWD = 2'd2;

   localparam logic CSR_TRAVEL     = 1'b0;
   localparam logic CSR_MIN_PERIOD = 1'b1;

   localparam int TRAVEL_RESET = 600;
   localparam logic [CSR_DATA_BITS-1:0] MIN_PERIOD_RESET = 16'd1200;
   localparam logic [TIME_BITS-1:0] PERIOD_RESET = 26'd1200;
   localparam logic [TIME_BITS-1:0] TENTH_RESET  = PERIOD_RESET / 10;
   localparam logic [TIME_BITS-1:0] TIME_MAX     = {TIME_BITS{1'b1}};

   localparam logic [9:0] MS_TO_US  = 10'd1000;
   // ceil(2^29 / 10), exact for any dividend below 2^26
   localparam logic [TIME_BITS-1:0] TENTH_RECIP = 26'd53687092;
   localparam int TENTH_SHIFT = 29;
   localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;
   localparam logic [PCT_BITS-1:0] PCT_CAP  = 7'd99;

   typedef enum logic [1:0] {
      PH_BEGIN,
      PH_RISE,
      PH_HIGH,
      PH_LOW
   } phase_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LATCH,
      DP_MUL_PERIOD,
      DP_DIV_PERIOD,
      DP_SET_PERIOD,
      DP_SET_TENTH,
      DP_TICK,
      DP_MUL_PROG,
      DP_DIV_PROG,
      DP_SET_PROG,
      DP_LOAD_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_PERIOD,
      ST_DIV_PERIOD,
      ST_WAIT_PERIOD,
      ST_SET_PERIOD,
      ST_SET_TENTH,
      ST_TICK,
      ST_MUL_PROG,
      ST_DIV_PROG,
      ST_WAIT_PROG,
      ST_SET_PROG,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic is_start;
      logic live_tick;
      logic step_complete;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/sspg_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on sspg_pkg
module sspg_div
   import sspg_pkg::*;
#(
   parameter int DIVISOR_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start_i,
   input  logic [TIME_BITS-1:0]    dividend_i,
   input  logic [DIVISOR_BITS-1:0] divisor_i,
   output logic                    done_o,
   output logic [TIME_BITS-1:0]    quotient_o
);

   localparam int CNT_BITS = $clog2(TIME_BITS + 1);

   logic [TIME_BITS-1:0]    quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0] divisor_ff, divisor_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIVISOR_BITS:0]   rem_shift;
   logic [DIVISOR_BITS:0]   rem_diff;
   logic                    fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[TIME_BITS-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = rem_shift >= {1'b0, divisor_ff};
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start_i) begin
         quo_in     = dividend_i;
         rem_in     = '0;
         divisor_in = divisor_i;
         count_in   = CNT_BITS'(TIME_BITS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[TIME_BITS-2:0], fits};
         rem_in   = fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done_o     = done_ff;
   assign quotient_o = quo_ff;

endmodule

[rtl/sspg_datapath.sv]
// datapath: configuration, stroke state, pulse timing, progress and result register
// depends on sspg_pkg, sspg_div and the assertion macro header
`include "stepper_stroke_pulse_generator_top_assert.svh"
module sspg_datapath
   import sspg_pkg::*;
#(
   parameter int STEP_COUNT_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic                     csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [DUR_BITS-1:0]      req_tdata,
   input  logic [CMD_BITS-1:0]      req_tuser,
   input  dp_op_type                op,
   output dp_status_type            status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [CMD_BITS-1:0]        cmd_ff, cmd_in;
   logic [DUR_BITS-1:0]        dur_ff, dur_in;
   logic [TIME_BITS-1:0]       product_ff, product_in;
   logic [STEP_COUNT_BITS-1:0] travel_ff, travel_in;
   logic [CSR_DATA_BITS-1:0]   minp_ff, minp_in;
   logic [STEP_COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic [TIME_BITS-1:0]       elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]       period_ff, period_in;
   logic [TIME_BITS-1:0]       tenth_ff, tenth_in;
   phase_type                  phase_ff, phase_in;
   logic                       dir_ff, dir_in;
   logic [PCT_BITS-1:0]        progress_ff, progress_in;
   logic                       alarm_ff, alarm_in;
   logic                       done_ff, done_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic                       div_start;
   logic [TIME_BITS-1:0]       div_dividend;
   logic [STEP_COUNT_BITS-1:0] div_divisor;
   logic                       div_done;
   logic [TIME_BITS-1:0]       div_quotient;

   logic                       below_min;
   logic [TIME_BITS-1:0]       period_clamped;
   logic [2*TIME_BITS-1:0]     tenth_prod;
   logic [TIME_BITS-1:0]       tenth_calc;
   logic [TIME_BITS-1:0]       elapsed_inc;
   logic                       step_complete;
   logic                       out_free;
   logic [PCT_BITS-1:0]        progress_calc;

   sspg_div #(
      .DIVISOR_BITS(STEP_COUNT_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (div_dividend),
      .divisor_i  (div_divisor),
      .done_o     (div_done),
      .quotient_o (div_quotient)
   );

   always_comb begin
      below_min      = div_quotient < TIME_BITS'(minp_ff);
      period_clamped = below_min ? TIME_BITS'(minp_ff) : div_quotient;
      tenth_prod     = (2*TIME_BITS)'(period_ff) * (2*TIME_BITS)'(TENTH_RECIP);
      tenth_calc     = TIME_BITS'(tenth_prod[2*TIME_BITS-1:TENTH_SHIFT]);
      elapsed_inc    = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      step_complete  = (phase_ff == PH_LOW) && (elapsed_inc >= period_ff);
      out_free       = !rsp_valid_ff || rsp_tready;

      div_start    = (op == DP_DIV_PERIOD) || (op == DP_DIV_PROG);
      div_dividend = product_ff;
      div_divisor  = travel_ff;

      if (remaining_ff == '0) begin
         progress_calc = PCT_FULL;
      end else if (travel_ff == '0) begin
         progress_calc = '0;
      end else if (div_quotient > TIME_BITS'(PCT_FULL)) begin
         progress_calc = '0;
      end else if (div_quotient == '0) begin
         progress_calc = PCT_CAP;
      end else begin
         progress_calc = PCT_FULL - div_quotient[PCT_BITS-1:0];
      end
   end

   always_comb begin
      travel_in = travel_ff;
      minp_in   = minp_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_TRAVEL: begin
               travel_in = csr_wdata[STEP_COUNT_BITS-1:0];
            end
            CSR_MIN_PERIOD: begin
               minp_in = csr_wdata;
            end
            default: begin
               travel_in = travel_ff;
            end
         endcase
      end
   end

   always_comb begin
      cmd_in       = cmd_ff;
      dur_in       = dur_ff;
      product_in   = product_ff;
      remaining_in = remaining_ff;
      elapsed_in   = elapsed_ff;
      period_in    = period_ff;
      tenth_in     = tenth_ff;
      phase_in     = phase_ff;
      dir_in       = dir_ff;
      progress_in  = progress_ff;
      alarm_in     = alarm_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (op)
         DP_LATCH: begin
            cmd_in   = req_tuser;
            dur_in   = req_tdata;
            alarm_in = 1'b0;
            done_in  = 1'b0;
         end
         DP_MUL_PERIOD: begin
            product_in = TIME_BITS'(dur_ff) * TIME_BITS'(MS_TO_US);
         end
         DP_SET_PERIOD: begin
            period_in    = period_clamped;
            alarm_in     = below_min;
            dir_in       = (cmd_ff == CMD_START_FWD);
            progress_in  = '0;
            remaining_in = travel_ff;
            elapsed_in   = '0;
         end
         DP_SET_TENTH: begin
            tenth_in = tenth_calc;
         end
         DP_TICK: begin
            if (phase_ff == PH_BEGIN) begin
               elapsed_in = '0;
               phase_in   = PH_RISE;
            end else begin
               elapsed_in = elapsed_inc;
               case (phase_ff)
                  PH_RISE: begin
                     if (elapsed_inc >= tenth_ff) phase_in = PH_HIGH;
                  end
                  PH_HIGH: begin
                     if (elapsed_inc >= {1'b0, period_ff[TIME_BITS-1:1]}) phase_in = PH_LOW;
                  end
                  default: begin
                     if (step_complete) begin
                        remaining_in = remaining_ff - 1'b1;
                        phase_in     = PH_BEGIN;
                        done_in      = 1'b1;
                     end
                  end
               endcase
            end
         end
         DP_MUL_PROG: begin
            product_in = TIME_BITS'(remaining_ff) * TIME_BITS'(PCT_FULL);
         end
         DP_SET_PROG: begin
            progress_in = progress_calc;
         end
         DP_LOAD_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {4'b0000, done_ff, alarm_ff, progress_ff,
                            (remaining_ff != '0), dir_ff, (phase_ff == PH_HIGH)};
         end
         default: begin
            cmd_in = cmd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      dur_ff      <= dur_in;
      product_ff  <= product_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         travel_ff    <= STEP_COUNT_BITS'(TRAVEL_RESET);
         minp_ff      <= MIN_PERIOD_RESET;
         remaining_ff <= '0;
         elapsed_ff   <= '0;
         period_ff    <= PERIOD_RESET;
         tenth_ff     <= TENTH_RESET;
         phase_ff     <= PH_BEGIN;
         dir_ff       <= 1'b0;
         progress_ff  <= '0;
         alarm_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         travel_ff    <= travel_in;
         minp_ff      <= minp_in;
         remaining_ff <= remaining_in;
         elapsed_ff   <= elapsed_in;
         period_ff    <= period_in;
         tenth_ff     <= tenth_in;
         phase_ff     <= phase_in;
         dir_ff       <= dir_in;
         progress_ff  <= progress_in;
         alarm_ff     <= alarm_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.is_start      = (cmd_ff == CMD_START_FWD) || (cmd_ff == CMD_START_BWD);
   assign status.live_tick     = (cmd_ff == CMD_TICK) && (remaining_ff != '0);
   assign status.step_complete = step_complete;
   assign status.div_done      = div_done;
   assign status.out_free      = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SSPG_ASSERT_NOW(a_progress_range, clock, reset, 1'b1, progress_ff <= PCT_FULL, "progress above full")
   `SSPG_ASSERT_NEXT(a_step_countdown, clock, reset, op == DP_TICK && step_complete, remaining_ff == STEP_COUNT_BITS'($past(remaining_ff) - 1'b1) && phase_ff == PH_BEGIN, "step end did not count down")
   `SSPG_ASSERT_NEXT(a_start_reload, clock, reset, op == DP_SET_PERIOD, elapsed_ff == '0 && remaining_ff == $past(travel_ff), "start did not reload the stroke")

endmodule

[rtl/sspg_ctrl.sv]
// controller state machine sequencing the datapath per item
// depends on sspg_pkg
module sspg_ctrl
   import sspg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_op_type     op
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.is_start) begin
               state_in = ST_MUL_PERIOD;
            end else if (status.live_tick) begin
               state_in = ST_TICK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MUL_PERIOD: begin
            state_in = ST_DIV_PERIOD;
         end
         ST_DIV_PERIOD: begin
            state_in = ST_WAIT_PERIOD;
         end
         ST_WAIT_PERIOD: begin
            if (status.div_done) state_in = ST_SET_PERIOD;
         end
         ST_SET_PERIOD: begin
            state_in = ST_SET_TENTH;
         end
         ST_SET_TENTH: begin
            state_in = ST_OUT;
         end
         ST_TICK: begin
            state_in = status.step_complete ? ST_MUL_PROG : ST_OUT;
         end
         ST_MUL_PROG: begin
            state_in = ST_DIV_PROG;
         end
         ST_DIV_PROG: begin
            state_in = ST_WAIT_PROG;
         end
         ST_WAIT_PROG: begin
            if (status.div_done) state_in = ST_SET_PROG;
         end
         ST_SET_PROG: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      op         = DP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) op = DP_LATCH;
         end
         ST_MUL_PERIOD: begin
            op = DP_MUL_PERIOD;
         end
         ST_DIV_PERIOD: begin
            op = DP_DIV_PERIOD;
         end
         ST_SET_PERIOD: begin
            op = DP_SET_PERIOD;
         end
         ST_SET_TENTH: begin
            op = DP_SET_TENTH;
         end
         ST_TICK: begin
            op = DP_TICK;
         end
         ST_MUL_PROG: begin
            op = DP_MUL_PROG;
         end
         ST_DIV_PROG: begin
            op = DP_DIV_PROG;
         end
         ST_SET_PROG: begin
            op = DP_SET_PROG;
         end
         ST_OUT: begin
            if (status.out_free) op = DP_LOAD_OUT;
         end
         default: begin
            op = DP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/stepper_stroke_pulse_generator_top.sv]
// Stepper stroke pulse generator. Every item on the request channel gives exactly one result.
// An idle tick or an unused command goes from decode straight to the result register,
// a tick that does not end a step passes the tick state first; a tick that ends a step
// also passes the progress figure once through the shared restoring divider; a start
// command makes one pass through that divider for the period from duration and travel,
// then forms period/10 by a reciprocal multiply. The divider gives one quotient bit per cycle.
// A new item can be taken once the previous result is in the result register, even while
// that result still waits.
// top level: instantiates sspg_ctrl and sspg_datapath; depends on sspg_pkg
module stepper_stroke_pulse_generator_top
   import sspg_pkg::*;
#(
   parameter int STEP_COUNT_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic                     csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DUR_BITS-1:0]      req_tdata,  // duration_ms
   input  logic [CMD_BITS-1:0]      req_tuser,  // cmd
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // step_pin, dir_forward, moving, progress_pct[6:0], underspeed_alarm, step_done, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   dp_op_type     op;
   dp_status_type status;

   sspg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   sspg_datapath #(
      .STEP_COUNT_BITS(STEP_COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op         (op),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[dv/tb_stepper_stroke_pulse_generator_top.sv]
`timescale 1ns / 100ps
// testbench for stepper_stroke_pulse_generator_top: directed strokes, then random strokes
// under bursty requests and result back-pressure, each result checked against a local predictor
// depends on sspg_pkg and the rtl top level
module tb_stepper_stroke_pulse_generator_top;
   import sspg_pkg::*;

   localparam int STEP_BITS = 10;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int STROKE_ITEMS = 1800;

   typedef struct packed {
      logic [3:0]          fill;
      logic                step_done;
      logic                alarm;
      logic [PCT_BITS-1:0] pct;
      logic                moving;
      logic                dir_fwd;
      logic                step_pin;
   } pulse_status_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wen = 1'b0;
   logic                     csr_addr = 1'b0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DUR_BITS-1:0]      req_tdata = '0;
   logic [CMD_BITS-1:0]      req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   // predictor state
   logic [STEP_BITS-1:0]     travel_q;
   logic [CSR_DATA_BITS-1:0] min_period_q;
   logic [STEP_BITS-1:0]     steps_left_q;
   logic [TIME_BITS-1:0]     elapsed_q;
   logic [TIME_BITS-1:0]     period_q;
   phase_type                phase_q;
   logic                     fwd_q;
   logic [PCT_BITS-1:0]      pct_q;

   pulse_status_type stroke_status_fifo[$];
   pulse_status_type got_status;
   pulse_status_type want_status;
   int               mismatches = 0;
   int               items_done = 0;
   int               burst_left = 8;
   bit               gaps_on = 1'b1;
   int               stall_mode = 1;
   logic [7:0]       stall_mask = 8'hFF;
   logic [7:0]       stall_tick = 8'd0;

   stepper_stroke_pulse_generator_top #(
      .STEP_COUNT_BITS(STEP_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [PCT_BITS-1:0] stroke_pct();
      int part;
      if (steps_left_q == 0) return PCT_FULL;
      if (travel_q == 0) return '0;
      part = (int'(steps_left_q) * 100) / int'(travel_q);
      if (part > 100) return '0;
      part = 100 - part;
      return (part >= 100) ? PCT_CAP : PCT_BITS'(part);
   endfunction

   function automatic pulse_status_type compute_stroke_status(input logic [CMD_BITS-1:0] cmd,
                                                              input logic [DUR_BITS-1:0] dur);
      pulse_status_type s;
      logic [31:0]      per;
      s = '0;
      if (cmd == CMD_START_FWD || cmd == CMD_START_BWD) begin
         if (travel_q == 0) begin
            per = 32'(TIME_MAX);
         end else begin
            per = (32'(dur) * 32'd1000) / 32'(travel_q);
         end
         if (per < 32'(min_period_q)) begin
            per = 32'(min_period_q);
            s.alarm = 1'b1;
         end
         period_q = per[TIME_BITS-1:0];
         fwd_q = (cmd == CMD_START_FWD);
         pct_q = '0;
         steps_left_q = travel_q;
         elapsed_q = '0;
      end else if (cmd == CMD_TICK && steps_left_q != 0) begin
         if (phase_q == PH_BEGIN) begin
            elapsed_q = '0;
            phase_q = PH_RISE;
         end else begin
            if (elapsed_q != TIME_MAX) elapsed_q = elapsed_q + 1'b1;
            case (phase_q)
               PH_RISE: begin
                  if (elapsed_q >= period_q / 10) phase_q = PH_HIGH;
               end
               PH_HIGH: begin
                  if (elapsed_q >= period_q / 2) phase_q = PH_LOW;
               end
               default: begin
                  if (elapsed_q >= period_q) begin
                     steps_left_q = steps_left_q - 1'b1;
                     phase_q = PH_BEGIN;
                     s.step_done = 1'b1;
                     pct_q = stroke_pct();
                  end
               end
            endcase
         end
      end
      s.step_pin = (phase_q == PH_HIGH);
      s.dir_fwd = fwd_q;
      s.moving = (steps_left_q != 0);
      s.pct = pct_q;
      return s;
   endfunction

   task automatic reset_model;
      travel_q = STEP_BITS'(TRAVEL_RESET);
      min_period_q = MIN_PERIOD_RESET;
      steps_left_q = '0;
      elapsed_q = '0;
      period_q = PERIOD_RESET;
      phase_q = PH_BEGIN;
      fwd_q = 1'b0;
      pct_q = '0;
   endtask

   task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [DUR_BITS-1:0] dur);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= dur;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == CMD_START_FWD || cmd == CMD_START_BWD || (cmd == CMD_TICK && steps_left_q != 0))
         items_done++;
      stroke_status_fifo.push_back(compute_stroke_status(cmd, dur));
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (stroke_status_fifo.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (addr == CSR_TRAVEL) begin
         travel_q = value[STEP_BITS-1:0];
      end else begin
         min_period_q = value;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata;
         if (stroke_status_fifo.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want_status = stroke_status_fifo.pop_front();
            if (got_status.step_pin !== want_status.step_pin
                || got_status.dir_fwd !== want_status.dir_fwd
                || got_status.moving !== want_status.moving
                || got_status.pct !== want_status.pct
                || got_status.alarm !== want_status.alarm
                || got_status.step_done !== want_status.step_done
                || got_status.fill !== want_status.fill) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pin %b dir %b mov %b pct %0d alm %b done %b | got %b %b %b %0d %b %b fill %h",
                           want_status.step_pin, want_status.dir_fwd, want_status.moving,
                           want_status.pct, want_status.alarm, want_status.step_done,
                           got_status.step_pin, got_status.dir_fwd, got_status.moving,
                           got_status.pct, got_status.alarm, got_status.step_done,
                           got_status.fill);
            end
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick[4:0] == 5'd0) stall_mask <= 8'($urandom) | 8'd1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= stall_mask[stall_tick[2:0]];
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic test_reset_defaults;
      send_item(CMD_TICK, 16'h0000);
      send_item(CMD_UNUSED, 16'hFFFF);
      send_item(CMD_START_FWD, 16'h0000);
      send_item(CMD_TICK, 16'hFFFF);
      send_item(CMD_TICK, 16'h0000);
      send_item(CMD_UNUSED, 16'h5A5A);
      send_item(CMD_START_BWD, 16'hFFFF);
      send_item(CMD_TICK, 16'h0001);
   endtask

   task automatic test_zero_travel;
      drain;
      write_reg(CSR_TRAVEL, 16'd0);
      send_item(CMD_START_FWD, 16'hA5A5);
      send_item(CMD_TICK, 16'h0000);
      drain;
      write_reg(CSR_TRAVEL, 16'd1023);
      write_reg(CSR_MIN_PERIOD, 16'hFFFF);
      send_item(CMD_START_BWD, 16'h0000);
      send_item(CMD_TICK, 16'h0000);
      send_item(CMD_TICK, 16'h0000);
   endtask

   task automatic test_zero_min_period;
      drain;
      write_reg(CSR_TRAVEL, 16'd1);
      write_reg(CSR_MIN_PERIOD, 16'd0);
      send_item(CMD_START_BWD, 16'h0000);
      repeat (5) send_item(CMD_TICK, 16'h0000);
   endtask

   task automatic test_restart_and_shrink;
      drain;
      write_reg(CSR_TRAVEL, 16'd4);
      write_reg(CSR_MIN_PERIOD, 16'd1);
      send_item(CMD_START_FWD, 16'h0000);
      repeat (2) send_item(CMD_TICK, 16'h0000);
      // restart while the pin is high
      send_item(CMD_START_BWD, 16'h0000);
      repeat (4) send_item(CMD_TICK, 16'h0000);
      // travel lowered below the remaining steps, upper data bits set
      drain;
      write_reg(CSR_TRAVEL, 16'hFC01);
      repeat (4) send_item(CMD_TICK, 16'h0000);
      drain;
      write_reg(CSR_TRAVEL, 16'hFC00);
      repeat (4) send_item(CMD_TICK, 16'h0000);
   endtask

   task automatic test_random_strokes;
      int               kind;
      int               n;
      int               est;
      int               pick;
      longint           span;
      logic [DUR_BITS-1:0] dur;
      while (items_done < STROKE_ITEMS) begin
         drain;
         gaps_on = ($urandom_range(0, 3) != 0);
         stall_mode = $urandom_range(0, 2);
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3, 4, 5: begin
               write_reg(CSR_TRAVEL, 16'($urandom_range(1, 6)));
               write_reg(CSR_MIN_PERIOD, 16'($urandom_range(0, 12)));
            end
            6, 7: begin
               write_reg(CSR_TRAVEL, 16'($urandom_range(300, 1023)));
               write_reg(CSR_MIN_PERIOD, 16'($urandom_range(0, 8)));
            end
            8: begin
               write_reg(CSR_TRAVEL, 16'($urandom));
               write_reg(CSR_MIN_PERIOD, 16'($urandom));
            end
            default: begin
               write_reg(CSR_TRAVEL, $urandom_range(0, 1) ? 16'd1023 : 16'd1);
               pick = $urandom_range(0, 2);
               write_reg(CSR_MIN_PERIOD, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : 16'hFFFF);
            end
         endcase
         repeat (3) begin
            case (kind)
               0, 1, 2, 3, 4, 5: dur = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0;
               6, 7: dur = 16'($urandom_range(0, 20));
               default: dur = 16'($urandom);
            endcase
            send_item($urandom_range(0, 1) ? CMD_START_FWD : CMD_START_BWD, dur);
            span = longint'(travel_q) * (longint'(period_q) + 3) + 4;
            est = (span > 150) ? 150 : int'(span);
            n = $urandom_range(est / 2, est + 8);
            repeat (n) begin
               pick = $urandom_range(0, 79);
               if (pick == 0) begin
                  send_item(CMD_UNUSED, 16'($urandom));
               end else if (pick == 1) begin
                  send_item($urandom_range(0, 1) ? CMD_START_FWD : CMD_START_BWD,
                            16'($urandom_range(0, 3)));
               end else begin
                  send_item(CMD_TICK, 16'($urandom));
               end
            end
         end
      end
   endtask

   initial begin
      reset_model;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults;
      test_zero_travel;
      test_zero_min_period;
      test_restart_and_shrink;
      test_random_strokes;
      drain;
      repeat (64) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
